[design/assert_macros.svh]
// assertion macros used by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every rising clock edge out of reset
`define ASSERT_PROP(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// expression must never be true on a rising clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

[design/ps2d_pkg.sv]
// shared types and constants for the ps/2 mouse packet decoder
`default_nettype none
package ps2d_pkg;

	localparam int unsigned SYNC_BIT      = 3;
	localparam logic [7:0]  RESET_MAX_COL = 8'd200;
	localparam logic [7:0]  RESET_MAX_ROW = 8'd60;
	localparam logic [7:0]  RESET_COLUMN  = 8'd40;
	localparam logic [7:0]  RESET_ROW     = 8'd12;
	localparam int unsigned DESC_DEPTH    = 2;
	localparam int unsigned EVT_DEPTH     = 2;

	typedef enum logic [1:0] {
		CFG_ENABLED = 2'd0,
		CFG_MAX_COL = 2'd1,
		CFG_MAX_ROW = 2'd2
	} cfg_idx_t;

	typedef enum logic {
		EV_MOTION = 1'b0,
		EV_BUTTON = 1'b1
	} ev_kind_t;

	typedef enum logic {
		ACT_PRESS   = 1'b0,
		ACT_RELEASE = 1'b1
	} ev_action_t;

	typedef struct packed {
		logic       enabled;
		logic [7:0] max_col;
		logic [7:0] max_row;
	} cfg_t;

	// one decoded packet that causes at least one event
	typedef struct packed {
		logic              motion;
		logic signed [8:0] dx;
		logic signed [8:0] dy;
		logic [2:0]        btn;
		logic [2:0]        changed;
	} desc_t;

	typedef struct packed {
		logic              event_kind;
		logic              action;
		logic [1:0]        button;
		logic signed [8:0] x_value;
		logic signed [8:0] y_value;
		logic              last;
		logic [7:0]        cursor_col;
		logic [7:0]        cursor_row;
		logic              cursor_shown;
	} event_t;

endpackage
`default_nettype wire

[design/ps2d_fifo.sv]
// small register queue used for the packet queue and the event output queue
`default_nettype none
module ps2d_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[design/ps2d_front.sv]
// byte gatherer and packet classifier
`default_nettype none
module ps2d_front (
	input  logic            clk,
	input  logic            arst_n,
	input  ps2d_pkg::cfg_t  cfg,
	input  logic            push,
	input  logic [7:0]      data_byte,
	output logic            full,
	input  logic            q_full,
	output logic            desc_push,
	output ps2d_pkg::desc_t desc
);
	import ps2d_pkg::*;

	logic [1:0] phase_q;
	logic [7:0] byte0_q;
	logic [7:0] byte1_q;
	logic [2:0] prev_btn_q;

	logic accept;
	logic pkt_done;
	logic sync_ok;
	logic ovf;

	assign full     = q_full;
	assign accept   = push && !q_full && cfg.enabled;
	// phase three never happens, treated like phase two
	assign pkt_done = accept && phase_q[1];
	assign sync_ok  = byte0_q[SYNC_BIT];
	assign ovf      = |byte0_q[7:6];

	always_comb begin
		desc.dx      = ovf ? 9'sd0 : signed'({byte0_q[4], byte1_q});
		desc.dy      = ovf ? 9'sd0 : signed'({byte0_q[5], data_byte});
		desc.btn     = byte0_q[2:0];
		desc.changed = byte0_q[2:0] ^ prev_btn_q;
		desc.motion  = (desc.dx != 9'sd0) || (desc.dy != 9'sd0);
		desc_push    = pkt_done && sync_ok && (desc.motion || (desc.changed != 3'b000));
	end

	always_ff @(posedge clk) begin
		if (accept && !phase_q[1]) begin
			if (phase_q[0]) begin
				byte1_q <= data_byte;
			end else begin
				byte0_q <= data_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 2'd0;
			prev_btn_q <= 3'b000;
		end else if (accept) begin
			if (!phase_q[1]) begin
				phase_q <= phase_q + 2'd1;
			end else begin
				phase_q <= 2'd0;
				if (sync_ok) begin
					prev_btn_q <= byte0_q[2:0];
				end
			end
		end
	end

endmodule
`default_nettype wire

[design/ps2d_back.sv]
// cursor tracker and event sequencer
`default_nettype none
`include "assert_macros.svh"
module ps2d_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ps2d_pkg::cfg_t   cfg,
	input  logic             desc_empty,
	input  ps2d_pkg::desc_t  desc,
	output logic             desc_pop,
	input  logic             evt_full,
	output logic             evt_push,
	output ps2d_pkg::event_t evt
);
	import ps2d_pkg::*;

	logic              busy_q;
	logic              motion_q;
	logic [2:0]        pend_q;
	logic [2:0]        btn_q;
	logic signed [8:0] dx_q;
	logic signed [8:0] dy_q;
	logic [7:0]        col_q;
	logic [7:0]        row_q;

	logic              emit;
	logic              emit_last;
	logic              can_load;
	logic              load;
	logic [1:0]        sel;
	logic [2:0]        low_mask;
	logic signed [9:0] col_sum;
	logic signed [9:0] row_sum;

	function automatic logic [7:0] clamp_axis(logic signed [9:0] v, logic [7:0] maxv);
		if (v < 10'sd0) begin
			return 8'd0;
		end
		if (v > signed'({2'b00, maxv})) begin
			return maxv;
		end
		return v[7:0];
	endfunction

	// lowest pending button goes first: left, right, middle
	always_comb begin
		case (1'b1)
			pend_q[0]: begin
				sel      = 2'd0;
				low_mask = 3'b001;
			end
			pend_q[1]: begin
				sel      = 2'd1;
				low_mask = 3'b010;
			end
			default: begin
				sel      = 2'd2;
				low_mask = 3'b100;
			end
		endcase
	end

	always_comb begin
		evt.cursor_col   = col_q;
		evt.cursor_row   = row_q;
		evt.cursor_shown = 1'b1;
		if (motion_q) begin
			evt.event_kind = EV_MOTION;
			evt.action     = ACT_PRESS;
			evt.button     = 2'd0;
			evt.x_value    = dx_q;
			evt.y_value    = dy_q;
			evt.last       = (pend_q == 3'b000);
		end else begin
			evt.event_kind = EV_BUTTON;
			evt.action     = btn_q[sel] ? ACT_PRESS : ACT_RELEASE;
			evt.button     = sel;
			evt.x_value    = signed'({1'b0, col_q});
			evt.y_value    = signed'({1'b0, row_q});
			evt.last       = ((pend_q & ~low_mask) == 3'b000);
		end
	end

	assign emit      = busy_q && !evt_full;
	assign evt_push  = emit;
	assign emit_last = emit && evt.last;
	assign can_load  = !busy_q || emit_last;
	assign load      = can_load && !desc_empty;
	assign desc_pop  = load;

	assign col_sum = signed'({2'b00, col_q}) + signed'({desc.dx[8], desc.dx});
	assign row_sum = signed'({2'b00, row_q}) - signed'({desc.dy[8], desc.dy});

	always_ff @(posedge clk) begin
		if (load) begin
			btn_q <= desc.btn;
			dx_q  <= desc.dx;
			dy_q  <= desc.dy;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			motion_q <= 1'b0;
			pend_q   <= 3'b000;
			col_q    <= RESET_COLUMN;
			row_q    <= RESET_ROW;
		end else if (load) begin
			busy_q   <= 1'b1;
			motion_q <= desc.motion;
			pend_q   <= desc.changed;
			if (desc.motion) begin
				col_q <= clamp_axis(col_sum, cfg.max_col);
				row_q <= clamp_axis(row_sum, cfg.max_row);
			end
		end else if (emit) begin
			if (motion_q) begin
				motion_q <= 1'b0;
			end else begin
				pend_q <= pend_q & ~low_mask;
			end
			if (evt.last) begin
				busy_q <= 1'b0;
			end
		end
	end

	`ASSERT_PROP(a_busy_has_work, clk, arst_n, busy_q |-> (motion_q || (pend_q != 3'b000)), "sequencer busy with no event left")
	`ASSERT_PROP(a_idle_after_last, clk, arst_n, (emit_last && !load) |=> !busy_q, "sequencer still busy after last event")
	`ASSERT_NEVER(a_load_over_work, clk, arst_n, desc_pop && busy_q && !emit_last, "packet taken while events still pending")

endmodule
`default_nettype wire

[design/ps2_mouse_packet_decoder.sv]
// top level of the ps/2 mouse packet decoder
// ps/2 mouse packet decoder. raw mouse bytes enter through a queue-style port (push/full)
// and are gathered three at a time into packets; while disabled every byte is taken and
// dropped. a packet whose status byte lacks the always-one bit is discarded and gathering
// restarts with the next byte. a packet that moves the cursor or changes a button yields a
// motion event (if any motion) and then one press/release event per changed button, left,
// right, middle; every event carries the cursor position after the whole packet, and 'last'
// marks the final event of a packet. events leave through a queue-style port (empty/pop).
// rate: one byte per cycle is taken while the packet queue has room; the event sequencer
// emits one event per cycle while the event queue has room, and it loads the next packet
// in the cycle it emits the last event of the current one. the first event of a packet
// passes through the packet queue, the sequencer registers and the event queue on its way
// to the outputs. configuration writes are taken in every cycle (cfg_ready is always high).
`default_nettype none
module ps2_mouse_packet_decoder #(
	parameter int unsigned DESC_DEPTH = ps2d_pkg::DESC_DEPTH,
	parameter int unsigned EVT_DEPTH  = ps2d_pkg::EVT_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	// configuration write channel
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	// byte input queue side
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	// event output queue side
	output logic              empty,
	input  logic              pop,
	output logic              event_kind,
	output logic              action,
	output logic [1:0]        button,
	output logic signed [8:0] x_value,
	output logic signed [8:0] y_value,
	output logic              last,
	output logic [7:0]        cursor_col,
	output logic [7:0]        cursor_row,
	output logic              cursor_shown
);
	import ps2d_pkg::*;

	localparam int unsigned DESC_W = $bits(desc_t);
	localparam int unsigned EVT_W  = $bits(event_t);

	cfg_t   cfg_q;
	desc_t  fr_desc;
	desc_t  bk_desc;
	event_t bk_evt;
	event_t out_evt;

	logic              fr_push;
	logic              desc_full;
	logic              desc_empty;
	logic              desc_pop;
	logic              evt_full;
	logic              evt_push;
	logic [DESC_W-1:0] desc_rd;
	logic [EVT_W-1:0]  evt_rd;

	// configuration registers, one transaction per cycle
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.max_col <= RESET_MAX_COL;
			cfg_q.max_row <= RESET_MAX_ROW;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ENABLED: cfg_q.enabled <= cfg_data[0];
				CFG_MAX_COL: cfg_q.max_col <= cfg_data;
				CFG_MAX_ROW: cfg_q.max_row <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: gathers bytes and classifies finished packets
	ps2d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.push      (push),
		.data_byte (data_byte),
		.full      (full),
		.q_full    (desc_full),
		.desc_push (fr_push),
		.desc      (fr_desc)
	);

	// packet queue between front and back
	ps2d_fifo #(
		.WIDTH (DESC_W),
		.DEPTH (DESC_DEPTH)
	) u_desc_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fr_push),
		.wr_data (fr_desc),
		.full    (desc_full),
		.rd_en   (desc_pop),
		.rd_data (desc_rd),
		.empty   (desc_empty)
	);

	assign bk_desc = desc_t'(desc_rd);

	// back: cursor tracking and event sequencing
	ps2d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.desc_empty (desc_empty),
		.desc       (bk_desc),
		.desc_pop   (desc_pop),
		.evt_full   (evt_full),
		.evt_push   (evt_push),
		.evt        (bk_evt)
	);

	// output queue decouples the sequencer from the consumer
	ps2d_fifo #(
		.WIDTH (EVT_W),
		.DEPTH (EVT_DEPTH)
	) u_evt_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (evt_push),
		.wr_data (bk_evt),
		.full    (evt_full),
		.rd_en   (pop),
		.rd_data (evt_rd),
		.empty   (empty)
	);

	assign out_evt      = event_t'(evt_rd);
	assign event_kind   = out_evt.event_kind;
	assign action       = out_evt.action;
	assign button       = out_evt.button;
	assign x_value      = out_evt.x_value;
	assign y_value      = out_evt.y_value;
	assign last         = out_evt.last;
	assign cursor_col   = out_evt.cursor_col;
	assign cursor_row   = out_evt.cursor_row;
	assign cursor_shown = out_evt.cursor_shown;

endmodule
`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the ps/2 mouse packet decoder
module tb;
	import ps2d_pkg::*;

	localparam int HOLD_CYCLES  = 300;       // long receiver hold-off, fills the block
	localparam int DRAIN_CYCLES = 16;        // settle time once no event is owed
	localparam int TIMEOUT_NS   = 5_000_000; // well above the slowest correct run
	localparam int PRINT_LIMIT  = 40;        // mismatch lines printed before going quiet

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [1:0]        cfg_index;
	logic [7:0]        cfg_data;
	logic              push;
	logic              full;
	logic [7:0]        data_byte;
	logic              empty;
	logic              pop;
	logic              event_kind;
	logic              action;
	logic [1:0]        button;
	logic signed [8:0] x_value;
	logic signed [8:0] y_value;
	logic              last;
	logic [7:0]        cursor_col;
	logic [7:0]        cursor_row;
	logic              cursor_shown;

	// predicted copy of the decoder: registers and packet state
	logic       p_enabled;
	logic [7:0] p_max_col;
	logic [7:0] p_max_row;
	logic [7:0] p_bytes [2];
	logic [1:0] p_phase;
	logic [2:0] p_buttons;
	logic [7:0] p_col;
	logic [7:0] p_row;
	logic       p_shown;

	// events the decoder still owes us, oldest first
	event_t pending_events [$];

	// run bookkeeping
	int  mismatches;
	int  bytes_sent;
	int  events_seen;
	int  packets_decoded;
	int  packets_lost_sync;
	int  stall_cycles;
	int  settings_applied;
	int  holdoffs_done;
	bit  send_idle;
	bit  recv_idle;
	bit  hold_req;

	ps2_mouse_packet_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.full         (full),
		.data_byte    (data_byte),
		.empty        (empty),
		.pop          (pop),
		.event_kind   (event_kind),
		.action       (action),
		.button       (button),
		.x_value      (x_value),
		.y_value      (y_value),
		.last         (last),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.cursor_shown (cursor_shown)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case a handshake never completes
	initial begin
		#(TIMEOUT_NS);
		$display("timeout after %0d bytes and %0d events", bytes_sent, events_seen);
		$display("ps2_mouse_packet_decoder verification failed");
		$finish;
	end

	// ---------------------------------------------------------------- helpers

	// idle length: mostly none or short, now and then a long one
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] clamp_axis(int v, logic [7:0] hi);
		if (v < 0)
			return 8'd0;
		if (v > int'(hi))
			return hi;
		return 8'(v);
	endfunction

	// one byte into the predicted decoder; queues any events the packet causes
	function automatic void decode_byte(logic [7:0] value);
		event_t     evs [$];
		event_t     ev;
		logic [7:0] status;
		logic [2:0] btn;
		logic [2:0] changed;
		int         dx;
		int         dy;
		if (!p_enabled)
			return;
		if (p_phase < 2) begin
			p_bytes[p_phase[0]] = value;
			p_phase = p_phase + 2'd1;
			return;
		end
		p_phase = 2'd0;
		status = p_bytes[0];
		if (!status[SYNC_BIT]) begin
			packets_lost_sync++;
			return;
		end
		packets_decoded++;
		// 9-bit deltas, sign bits live in the status byte
		dx = int'(p_bytes[1]) - (status[4] ? 256 : 0);
		dy = int'(value) - (status[5] ? 256 : 0);
		if (status[7] || status[6]) begin
			dx = 0;
			dy = 0;
		end
		btn = status[2:0];
		if (dx != 0 || dy != 0) begin
			// screen rows grow downwards, mouse dy grows upwards
			p_col = clamp_axis(int'(p_col) + dx, p_max_col);
			p_row = clamp_axis(int'(p_row) - dy, p_max_row);
			p_shown = 1'b1;
			ev = '0;
			ev.event_kind = EV_MOTION;
			ev.action = ACT_PRESS;
			ev.x_value = dx[8:0];
			ev.y_value = dy[8:0];
			evs.push_back(ev);
		end
		changed = btn ^ p_buttons;
		for (int i = 0; i < 3; i++) begin
			if (changed[i]) begin
				ev = '0;
				ev.event_kind = EV_BUTTON;
				ev.action = btn[i] ? ACT_PRESS : ACT_RELEASE;
				ev.button = 2'(i);
				ev.x_value = {1'b0, p_col};
				ev.y_value = {1'b0, p_row};
				p_shown = 1'b1;
				evs.push_back(ev);
			end
		end
		p_buttons = btn;
		// cursor fields carry the state after the whole packet
		for (int k = 0; k < evs.size(); k++) begin
			ev = evs[k];
			ev.last = (k == evs.size() - 1);
			ev.cursor_col = p_col;
			ev.cursor_row = p_row;
			ev.cursor_shown = p_shown;
			pending_events.push_back(ev);
		end
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("%0t ns mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input logic [8:0] seen,
			input logic [8:0] wanted);
		if (seen !== wanted)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h (event %0d)",
				name, seen, wanted, events_seen));
	endtask

	// sender side: optional gap in front, then hold push until the transaction
	task automatic send_byte(input logic [7:0] value);
		int gap;
		gap = send_idle ? idle_gap() : 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		data_byte <= value;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bytes_sent++;
		decode_byte(value);
	endtask

	task automatic send_packet(input logic [7:0] status, input logic [7:0] dx_byte,
			input logic [7:0] dy_byte);
		send_byte(status);
		send_byte(dx_byte);
		send_byte(dy_byte);
	endtask

	// mostly well-formed packets with random content, the rest noise and bad sync
	task automatic send_random_packet();
		logic [7:0] status;
		logic [7:0] dx_byte;
		logic [7:0] dy_byte;
		int         r;
		int         fill;
		r = $urandom_range(0, 99);
		if (r < 6) begin
			// stray bytes shift the framing, nothing resyncs it
			repeat ($urandom_range(1, 2))
				send_byte(8'($urandom));
			return;
		end
		status = 8'($urandom);
		if (r < 12) begin
			status[SYNC_BIT] = 1'b0;
		end else begin
			// usually realign the framing first so the packet lands whole
			fill = (3 - p_phase) % 3;
			if (p_enabled && fill != 0 && $urandom_range(0, 3) != 0)
				repeat (fill)
					send_byte(8'($urandom));
			status[SYNC_BIT] = 1'b1;
			if ($urandom_range(0, 99) < 85)
				status[7:6] = 2'b00;
			if ($urandom_range(0, 99) < 30)
				status[2:0] = p_buttons;
		end
		dx_byte = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		dy_byte = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom);
		send_packet(status, dx_byte, dy_byte);
	endtask

	task automatic send_random_bytes(input int count);
		int target;
		target = bytes_sent + count;
		while (bytes_sent < target)
			send_random_packet();
	endtask

	// register write; the caller lowers cfg_valid after its last write
	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_ENABLED: p_enabled = value[0];
			CFG_MAX_COL: p_max_col = value;
			CFG_MAX_ROW: p_max_row = value;
			default: ;
		endcase
	endtask

	task automatic configure(input bit en, input logic [7:0] col_hi,
			input logic [7:0] row_hi);
		write_reg(CFG_ENABLED, {7'd0, en});
		write_reg(CFG_MAX_COL, col_hi);
		write_reg(CFG_MAX_ROW, row_hi);
		cfg_valid <= 1'b0;
		settings_applied++;
	endtask

	// stop offering, wait for every owed event, then let a quiet packet settle
	task automatic wait_idle();
		push <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------ result side

	// receiver: random pop gaps, or a long hold-off when a test asks for one
	initial begin : pop_driver
		int stall;
		stall = 0;
		pop = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				holdoffs_done++;
			end else if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				if (recv_idle)
					stall = idle_gap();
			end
		end
	end

	// every accepted event against the oldest prediction, field by field
	always @(posedge clk) begin : event_checker
		event_t got;
		event_t want;
		if (arst_n) begin
			if (push && full)
				stall_cycles++;
			if (pop && !empty) begin
				got = '{event_kind, action, button, x_value, y_value, last,
					cursor_col, cursor_row, cursor_shown};
				if (pending_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event kind %0d button %0d x %0d y %0d",
						got.event_kind, got.button, got.x_value, got.y_value));
				end else begin
					want = pending_events.pop_front();
					check_field("event_kind", 9'(got.event_kind), 9'(want.event_kind));
					check_field("action", 9'(got.action), 9'(want.action));
					check_field("button", 9'(got.button), 9'(want.button));
					check_field("x_value", got.x_value, want.x_value);
					check_field("y_value", got.y_value, want.y_value);
					check_field("last", 9'(got.last), 9'(want.last));
					check_field("cursor_col", 9'(got.cursor_col), 9'(want.cursor_col));
					check_field("cursor_row", 9'(got.cursor_row), 9'(want.cursor_row));
					check_field("cursor_shown", 9'(got.cursor_shown), 9'(want.cursor_shown));
				end
				events_seen++;
			end
		end
	end

	// ------------------------------------------------------------------ tests

	// out of reset the decoder is off: bytes are taken and dropped
	task automatic test_disabled_drop();
		send_idle = 1'b1;
		recv_idle = 1'b1;
		repeat (5)
			send_byte(8'($urandom));
		wait_idle();
	endtask

	// hand-picked packets: field extremes, every event kind, the odd cases
	task automatic test_directed_packets();
		configure(1'b1, 8'd255, 8'd255);
		send_packet(8'h08, 8'h00, 8'h00); // quiet packet, nothing comes out
		send_packet(8'h1F, 8'h00, 8'hFF); // dx -256, dy +255, three presses
		send_packet(8'h28, 8'hFF, 8'h01); // dx +255, dy -255, three releases
		send_packet(8'h4A, 8'h10, 8'h10); // x overflow kills motion, right press
		send_packet(8'h88, 8'h33, 8'h44); // y overflow, right release
		send_packet(8'h05, 8'h11, 8'h22); // sync bit clear, packet lost
		send_packet(8'h09, 8'h00, 8'h00); // left press alone
		send_packet(8'h38, 8'h80, 8'h80); // both deltas -128, left release
		wait_idle();
	endtask

	// cursor clamping, including a maximum lowered below the cursor
	task automatic test_cursor_clamp();
		configure(1'b1, 8'd255, 8'd255);
		send_packet(8'h08, 8'h7F, 8'h00);
		send_packet(8'h28, 8'h7F, 8'h81);
		wait_idle();
		configure(1'b1, 8'd20, 8'd10);
		send_packet(8'h0C, 8'h00, 8'h00); // cursor still beyond the new maximum
		send_packet(8'h08, 8'h01, 8'h00); // first motion pulls it back in
		wait_idle();
		configure(1'b1, 8'd0, 8'd0);
		send_packet(8'h18, 8'hFF, 8'h00);
		send_packet(8'h08, 8'h00, 8'h01);
		wait_idle();
	endtask

	// random traffic across several register settings, extremes included
	task automatic test_random_settings();
		configure(1'b1, RESET_MAX_COL, RESET_MAX_ROW);
		send_random_bytes(40);
		wait_idle();
		configure(1'b1, 8'd0, 8'd0);
		send_random_bytes(40);
		wait_idle();
		// switching off mid-packet keeps the framing where it was
		configure(1'b0, 8'd255, 8'd255);
		send_random_bytes(40);
		wait_idle();
		configure(1'b1, 8'd255, 8'd255);
		send_random_bytes(40);
		wait_idle();
		configure(1'b1, 8'($urandom), 8'($urandom));
		send_random_bytes(40);
		wait_idle();
		configure(1'b1, 8'($urandom_range(1, 15)), 8'($urandom_range(1, 15)));
		send_random_bytes(40);
		wait_idle();
	endtask

	// receiver holds off while busy packets keep coming, so the input stalls
	task automatic test_backpressure();
		logic [7:0] status;
		configure(1'b1, 8'd160, 8'd100);
		while (p_phase != 2'd0)
			send_byte(8'($urandom));
		send_idle = 1'b0;
		hold_req = 1'b1;
		repeat (20) begin
			// every button flips and motion is nonzero: four events each
			status = {2'b00, 2'($urandom), 1'b1, ~p_buttons};
			send_packet(status, 8'($urandom_range(1, 255)), 8'($urandom));
		end
		wait_idle();
	endtask

	// back to back on both sides, no gaps at all
	task automatic test_full_rate();
		send_idle = 1'b0;
		recv_idle = 1'b0;
		send_random_bytes(60);
		wait_idle();
		send_idle = 1'b1;
		recv_idle = 1'b1;
	endtask

	initial begin : test_sequence
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ENABLED;
		cfg_data = 8'd0;
		push = 1'b0;
		data_byte = 8'd0;
		hold_req = 1'b0;
		send_idle = 1'b1;
		recv_idle = 1'b1;
		mismatches = 0;
		bytes_sent = 0;
		events_seen = 0;
		packets_decoded = 0;
		packets_lost_sync = 0;
		stall_cycles = 0;
		settings_applied = 0;
		holdoffs_done = 0;
		// predicted state as it leaves reset
		p_enabled = 1'b0;
		p_max_col = RESET_MAX_COL;
		p_max_row = RESET_MAX_ROW;
		p_bytes[0] = 8'd0;
		p_bytes[1] = 8'd0;
		p_phase = 2'd0;
		p_buttons = 3'd0;
		p_col = RESET_COLUMN;
		p_row = RESET_ROW;
		p_shown = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_disabled_drop();
		test_directed_packets();
		test_cursor_clamp();
		test_random_settings();
		test_backpressure();
		test_full_rate();
		wait_idle();

		if (pending_events.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", pending_events.size()));
		$display("covered %0d bytes, %0d packets decoded, %0d lost to bad sync, %0d events",
			bytes_sent, packets_decoded, packets_lost_sync, events_seen);
		$display("%0d register settings, %0d receiver hold-offs, %0d cycles of input stall",
			settings_applied, holdoffs_done, stall_cycles);
		if (mismatches == 0) begin
			$display("ps2_mouse_packet_decoder verification clean");
		end else begin
			$display("ps2_mouse_packet_decoder verification failed");
		end
		$finish;
	end

endmodule
